[design/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES package
// S-boxes, GF(2^8) helpers and the round functions shared by the cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  typedef logic [BlockW-1:0] block_t;

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  localparam logic [7:0] SboxFwd [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] SboxInv [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // Multiply by x modulo x^8 + x^4 + x^3 + x + 1.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte i sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input block_t s, input int i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t sub_shift_fwd(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(c*4+r) -: 8] = SboxFwd[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    sub_shift_fwd = t;
  endfunction

  function automatic block_t sub_shift_inv(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(c*4+r) -: 8] = SboxInv[get_byte(s, ((c - r + 4) % 4) * 4 + r)];
      end
    end
    sub_shift_inv = t;
  endfunction

  function automatic block_t mix_fwd(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4+1);
      a2 = get_byte(s, c*4+2);
      a3 = get_byte(s, c*4+3);
      t[BlockW-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BlockW-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BlockW-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_fwd = t;
  endfunction

  // Inverse mix as a premultiply by {04,00,05,00} followed by the forward mix.
  function automatic block_t mix_inv(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4+1);
      a2 = get_byte(s, c*4+2);
      a3 = get_byte(s, c*4+3);
      u  = xtime(xtime(a0 ^ a2));
      v  = xtime(xtime(a1 ^ a3));
      t[BlockW-1-8*(c*4)   -: 8] = a0 ^ u;
      t[BlockW-1-8*(c*4+1) -: 8] = a1 ^ v;
      t[BlockW-1-8*(c*4+2) -: 8] = a2 ^ u;
      t[BlockW-1-8*(c*4+3) -: 8] = a3 ^ v;
    end
    mix_inv = mix_fwd(t);
  endfunction

  // Next round key from the previous one.
  function automatic block_t key_step(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    g  = {SboxFwd[w3[23:16]] ^ rc, SboxFwd[w3[15:8]], SboxFwd[w3[7:0]], SboxFwd[w3[31:24]]};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage

[design/aes_round_stage.sv]
// ----------------------------------------------------------------------------
// AES round stage
// One registered round of the unrolled pipeline, encrypt or decrypt per item.
// ----------------------------------------------------------------------------
module aes_round_stage #(
  parameter int unsigned Round = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic           op_i,
  input  aes_pkg::block_t state_i,
  input  aes_pkg::block_t key_enc_i,
  input  aes_pkg::block_t key_dec_i,
  output logic           valid_o,
  output logic           op_o,
  output aes_pkg::block_t state_o
);
  import aes_pkg::*;

  localparam bit IsLast = (Round == NumRounds);

  block_t state_d, state_q;
  logic   valid_q, op_q;
  block_t enc_sb, dec_sb, dec_ak;

  // Encrypt: sub, shift, mix, add key. Decrypt: inv shift/sub, add key, inv mix. The last round skips the mix.
  always_comb begin
    enc_sb = sub_shift_fwd(state_i);
    dec_sb = sub_shift_inv(state_i);
    dec_ak = dec_sb ^ key_dec_i;
    if (op_i == OP_DEC) begin
      state_d = IsLast ? dec_ak : mix_inv(dec_ak);
    end else begin
      state_d = (IsLast ? enc_sb : mix_fwd(enc_sb)) ^ key_enc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      op_q    <= op_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign state_o = state_q;

endmodule

[design/aes128_block_cipher_top.sv]
// Data path: one key-add stage, ten round stages, one output register; one block
// accepted every cycle while the output is not stalled and the round keys are ready.
// The round keys are expanded into a chain of key-step registers; input ready stays
// low after reset and after each key write while the chain settles.
// Configure only while no transaction is in flight.
// Reset: asynchronous active low; clears all valid bits and the key to zero.
// ----------------------------------------------------------------------------
// AES-128 block cipher top
// Unrolled ten-round pipeline with a global stall, fixed key schedule registers.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [aes_pkg::HalfW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [aes_pkg::HalfW-1:0]       block_high_i,
  input  logic [aes_pkg::HalfW-1:0]       block_low_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [aes_pkg::HalfW-1:0]       result_high_o,
  output logic [aes_pkg::HalfW-1:0]       result_low_o
);
  import aes_pkg::*;

  localparam int unsigned SettleW = $clog2(NumRounds + 1);

  logic [HalfW-1:0]   key_high_q, key_low_q;
  block_t             rk_q [1:NumRounds];
  block_t             rk [NumRounds+1];
  logic [SettleW-1:0] settle_q;
  logic               key_ready;
  logic               en;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Round key chain: each register derives the next key from the previous one.
  assign rk[0] = {key_high_q, key_low_q};
  for (genvar r = 1; r <= NumRounds; r++) begin : g_keys
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rk_q[r] <= '0;
      end else begin
        rk_q[r] <= key_step(rk[r-1], Rcon[r-1]);
      end
    end
    assign rk[r] = rk_q[r];
  end

  // The settle counter, loaded with NumRounds on reset or a key write, reaches zero once the last round key is stable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleW'(NumRounds);
    end else if (cfg_we_i) begin
      settle_q <= SettleW'(NumRounds);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end
  assign key_ready = (settle_q == '0);

  // The whole pipeline advances unless the output holds an untaken result.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && key_ready;

  // Initial key add: round key 0 to encrypt, round key 10 to decrypt.
  logic   v0_q, op0_q;
  block_t s0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i && key_ready;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= op_i;
      s0_q  <= {block_high_i, block_low_i} ^ (op_i ? rk[NumRounds] : rk[0]);
    end
  end

  logic   vs [NumRounds+1];
  logic   ops [NumRounds+1];
  block_t ss [NumRounds+1];
  assign vs[0]  = v0_q;
  assign ops[0] = op0_q;
  assign ss[0]  = s0_q;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_rounds
    aes_round_stage #(.Round(r)) u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (vs[r-1]),
      .op_i      (ops[r-1]),
      .state_i   (ss[r-1]),
      .key_enc_i (rk[r]),
      .key_dec_i (rk[NumRounds-r]),
      .valid_o   (vs[r]),
      .op_o      (ops[r]),
      .state_o   (ss[r])
    );
  end

  // Output register.
  logic   out_valid_q;
  block_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vs[NumRounds];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= ss[NumRounds];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_q[BlockW-1 -: HalfW];
  assign result_low_o  = res_q[HalfW-1:0];

endmodule
